// ----- rtl/bump_and_size_class_allocator_top_macros.svh -----
// Assertion macros shared by the allocator checker
`ifndef BUMP_AND_SIZE_CLASS_ALLOCATOR_TOP_MACROS_SVH
`define BUMP_AND_SIZE_CLASS_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define BSA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled while reset is held
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ----- rtl/bsa_pkg.sv -----
// Shared types, codes and defaults for the bump and size class allocator
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int DEF_NUM_CLASSES  = 64;
  localparam int DEF_LIST_DEPTH   = 16;
  localparam int DEF_HEADER_BYTES = 16;

  localparam int OPCODE_W  = 2;
  localparam int SIZE_W    = 16;
  localparam int ADDR_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SET_TOP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_BUMPED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LIST_FULL = 3'd5;
  localparam logic [STATUS_W-1:0] ST_LISTS_OFF = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_BUMP_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUMP_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LISTS_EN   = 2'd2;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
    logic pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic pop_needed;
  } dp_status_t;

endpackage

// ----- rtl/bsa_ctrl.sv -----
// Controller state machine for the allocator
`timescale 1ns / 1ps

module bsa_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  bsa_pkg::dp_status_t    dp_stat,
  output bsa_pkg::ctrl_cmd_t     cmd,
  output logic                   busy
);
  import bsa_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_POP   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (dp_stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = dp_stat.pop_needed ? S_POP : S_IDLE;
      end
      S_POP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.clear  = (state == S_CLEAR);
    cmd.accept = (state == S_IDLE) && start;
    cmd.exec   = (state == S_EXEC);
    cmd.pop    = (state == S_POP);
    busy       = (state != S_IDLE);
  end

endmodule

// ----- rtl/bsa_dp.sv -----
// Datapath: configuration, bump pointer, list pointer memory and slot memory
`timescale 1ns / 1ps

module bsa_dp #(
  parameter int NUM_CLASSES  = bsa_pkg::DEF_NUM_CLASSES,
  parameter int LIST_DEPTH   = bsa_pkg::DEF_LIST_DEPTH,
  parameter int HEADER_BYTES = bsa_pkg::DEF_HEADER_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bsa_pkg::ctrl_cmd_t                cmd,
  output bsa_pkg::dp_status_t               dp_stat,
  input  logic [bsa_pkg::OPCODE_W-1:0]      opcode,
  input  logic [bsa_pkg::SIZE_W-1:0]        size_bytes,
  input  logic [bsa_pkg::ADDR_W-1:0]        slot_address,
  input  logic                              cfg_write,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              done,
  output logic [bsa_pkg::STATUS_W-1:0]      status,
  output logic [bsa_pkg::ADDR_W-1:0]        payload_address
);
  import bsa_pkg::*;

  localparam int CLS_W      = $clog2(NUM_CLASSES);
  localparam int PTR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int ENT_W      = 2 * PTR_W + CNT_W;
  localparam int SLOT_DEPTH = NUM_CLASSES * (2 ** PTR_W);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [ADDR_W-1:0] bump_limit;
  logic              lists_en;
  logic [ADDR_W-1:0] bump_top;

  logic [OPCODE_W-1:0] req_op;
  logic [SIZE_W-1:0]   req_size;
  logic [ADDR_W-1:0]   req_slot;

  logic [ENT_W-1:0]  cls_mem [NUM_CLASSES];
  logic [ENT_W-1:0]  cls_q;
  logic [ADDR_W-1:0] slot_mem [SLOT_DEPTH];
  logic [ADDR_W-1:0] slot_q;
  logic [CLS_W-1:0]  clr_idx;

  logic [PTR_W-1:0] cls_head;
  logic [PTR_W-1:0] cls_tail;
  logic [CNT_W-1:0] cls_cnt;
  logic [CLS_W-1:0] req_class;
  logic             req_in_range;
  logic             in_range;
  logic [ADDR_W:0]  bump_sum;
  logic             bump_fits;

  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic                top_upd;
  logic [ADDR_W-1:0]   top_val;
  logic                cls_we;
  logic [ENT_W-1:0]    cls_wdata;
  logic                slot_we;
  logic                pop_needed;

  assign {cls_head, cls_tail, cls_cnt} = cls_q;
  assign req_class    = req_size[CLS_W-1:0];
  assign req_in_range = (req_size < SIZE_W'(NUM_CLASSES));
  assign in_range     = (size_bytes < SIZE_W'(NUM_CLASSES));
  assign bump_sum     = {1'b0, bump_top} + (ADDR_W + 1)'(HEADER_BYTES)
                      + (ADDR_W + 1)'(req_size);
  assign bump_fits    = (bump_sum <= {1'b0, bump_limit});

  always_comb begin
    res_status = ST_BAD_SIZE;
    res_addr   = '0;
    top_upd    = 1'b0;
    top_val    = bump_sum[ADDR_W-1:0];
    cls_we     = 1'b0;
    cls_wdata  = cls_q;
    slot_we    = 1'b0;
    pop_needed = 1'b0;
    unique case (req_op)
      OP_ALLOC: begin
        if (bump_fits) begin
          res_status = ST_BUMPED;
          res_addr   = bump_top + ADDR_W'(HEADER_BYTES);
          top_upd    = 1'b1;
        end else if (!lists_en) begin
          res_status = ST_NO_SPACE;
        end else if (!req_in_range) begin
          res_status = ST_BAD_SIZE;
        end else if (cls_cnt == '0) begin
          res_status = ST_NO_SPACE;
        end else begin
          res_status = ST_REUSED;
          pop_needed = 1'b1;
          cls_we     = 1'b1;
          cls_wdata  = {ptr_inc(cls_head), cls_tail, cls_cnt - 1'b1};
        end
      end
      OP_FREE: begin
        if (!lists_en) begin
          res_status = ST_LISTS_OFF;
        end else if (!req_in_range) begin
          res_status = ST_BAD_SIZE;
        end else if (req_slot == '0) begin
          res_status = ST_ACCEPTED;
        end else if (cls_cnt >= CNT_W'(LIST_DEPTH)) begin
          res_status = ST_LIST_FULL;
        end else begin
          res_status = ST_ACCEPTED;
          slot_we    = 1'b1;
          cls_we     = 1'b1;
          cls_wdata  = {cls_head, ptr_inc(cls_tail), cls_cnt + 1'b1};
        end
      end
      OP_SET_TOP: begin
        res_status = ST_ACCEPTED;
        top_upd    = 1'b1;
        top_val    = req_slot;
      end
      default: begin
        res_status = ST_BAD_SIZE;
      end
    endcase
  end

  assign dp_stat.pop_needed = pop_needed;
  assign dp_stat.clear_last = (clr_idx == CLS_W'(NUM_CLASSES - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op   <= opcode;
      req_size <= size_bytes;
      req_slot <= slot_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear && !dp_stat.clear_last) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      cls_mem[clr_idx] <= '0;
    end else if (cmd.exec && cls_we) begin
      cls_mem[req_class] <= cls_wdata;
    end
    if (cmd.accept && in_range) begin
      cls_q <= cls_mem[size_bytes[CLS_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && slot_we) begin
      slot_mem[{req_class, cls_tail}] <= req_slot;
    end
    if (cmd.exec && pop_needed) begin
      slot_q <= slot_mem[{req_class, cls_head}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bump_limit <= '0;
      lists_en   <= 1'b0;
      bump_top   <= '0;
    end else begin
      if (cmd.exec && top_upd) begin
        bump_top <= top_val;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_BUMP_START: begin
            bump_top <= cfg_data;
          end
          CFG_BUMP_LIMIT: begin
            bump_limit <= cfg_data;
          end
          CFG_LISTS_EN: begin
            lists_en <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.exec && !pop_needed) || cmd.pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status          <= res_status;
      payload_address <= res_addr;
    end else if (cmd.pop) begin
      status          <= ST_REUSED;
      payload_address <= slot_q;
    end
  end

endmodule

// ----- rtl/bump_and_size_class_allocator_top.sv -----
// Sequence: an accepted start moves to the execute state, and done is registered from it;
// a reuse from a free list adds a pop state, as the slot memory read waits on the head pointer from the list memory.
// A new request is taken only while idle, so the block finishes one request before taking the next.
// Reset: synchronous; control and configuration registers clear to zero, then a clearing
// pass over every class empties every list while busy stays high. Results cannot be stalled.
`timescale 1ns / 1ps

module bump_and_size_class_allocator_top #(
  parameter int NUM_CLASSES  = bsa_pkg::DEF_NUM_CLASSES,
  parameter int LIST_DEPTH   = bsa_pkg::DEF_LIST_DEPTH,
  parameter int HEADER_BYTES = bsa_pkg::DEF_HEADER_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [bsa_pkg::OPCODE_W-1:0]      opcode,
  input  logic [bsa_pkg::SIZE_W-1:0]        size_bytes,
  input  logic [bsa_pkg::ADDR_W-1:0]        slot_address,
  output logic                              done,
  output logic [bsa_pkg::STATUS_W-1:0]      status,
  output logic [bsa_pkg::ADDR_W-1:0]        payload_address,
  input  logic                              cfg_write,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bsa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_stat;

  bsa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .dp_stat (dp_stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  bsa_dp #(
    .NUM_CLASSES  (NUM_CLASSES),
    .LIST_DEPTH   (LIST_DEPTH),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .dp_stat         (dp_stat),
    .opcode          (opcode),
    .size_bytes      (size_bytes),
    .slot_address    (slot_address),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .status          (status),
    .payload_address (payload_address)
  );

endmodule

// ----- rtl/bsa_checker.sv -----
// Port-level checker for the allocator, bound to the top level
`timescale 1ns / 1ps
`include "bump_and_size_class_allocator_top_macros.svh"

module bsa_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic [bsa_pkg::OPCODE_W-1:0]      opcode,
  input logic [bsa_pkg::SIZE_W-1:0]        size_bytes,
  input logic [bsa_pkg::ADDR_W-1:0]        slot_address,
  input logic                              done,
  input logic [bsa_pkg::STATUS_W-1:0]      status,
  input logic [bsa_pkg::ADDR_W-1:0]        payload_address,
  input logic                              cfg_write,
  input logic [bsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [bsa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bsa_pkg::*;

  `BSA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `BSA_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `BSA_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `BSA_ASSERT_NOW(a_fail_null, clk, rst, done && status != ST_BUMPED && status != ST_REUSED,
    payload_address == '0)

endmodule

bind bump_and_size_class_allocator_top bsa_checker u_bsa_checker (.*);
